>>> design/bcfp_pkg.sv
`timescale 1ns / 1ps
package bcfp_pkg;
    localparam logic [1:0] CMD_BYTE = 2'd0;
    localparam logic [1:0] CMD_NAME_CHAR = 2'd1;
    localparam logic [1:0] CMD_NAME_LEN = 2'd2;
    localparam logic [1:0] CMD_IGNORED = 2'd3;

    localparam logic [1:0] KIND_PARAM = 2'd0;
    localparam logic [1:0] KIND_FOUND = 2'd1;
    localparam logic [1:0] KIND_UNKNOWN = 2'd2;
    localparam logic [1:0] KIND_OVERFLOW = 2'd3;

    localparam logic [7:0] CH_OPEN = 8'h3C;
    localparam logic [7:0] CH_CLOSE = 8'h3E;
    localparam logic [7:0] CH_ESC = 8'h5C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL = 8'h0A;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
        logic [3:0] slot;
        logic [3:0] char_pos;
        logic [4:0] name_length;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] command_index;
        logic [3:0] param_index;
        logic [7:0] param_byte;
        logic [3:0] param_total;
        logic       last;
    } out_item_t;
endpackage

>>> design/bcfp_stream_if.sv
`timescale 1ns / 1ps
interface bcfp_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> design/bracket_command_frame_parser_top.sv
`timescale 1ns / 1ps
// Frame parser for '<name params>' lines on a byte stream. Table writes and ordinary
// bytes are accepted one per cycle while idle and while no result is waiting.
// The closing '>' starts a sequencer that compares one buffer byte against one name
// character at a time through a single comparator and memory read port: each table
// entry takes a read and a compare per character, plus the check of the byte after
// the name; then the parameter walk reads and steps each remaining buffer byte, and
// each result passes through the output register, where it waits while the receiver
// holds off. Input ready is low while that runs and while a result waits.
module bracket_command_frame_parser_top #(
    parameter int BUF_BYTES = 32,
    parameter int NUM_CMDS = 16,
    parameter int NAME_LEN = 16,
    parameter int MAX_PARAMS = 10
) (
    input  logic clk,
    input  logic rst_n,
    bcfp_stream_if.sink   in_ch,
    bcfp_stream_if.source out_ch,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [4:0] cfg_data
);
    localparam int BW = $clog2(BUF_BYTES);
    localparam int FW = $clog2(BUF_BYTES + 1);
    localparam int NW = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1;
    localparam int CW = (NUM_CMDS > 1) ? $clog2(NUM_CMDS) : 1;
    localparam int TW = CW + NW;

    typedef enum logic [2:0] {S_IDLE, S_MREAD, S_MCMP, S_PREAD, S_PSTEP, S_SUM, S_OUT}
        state_t;

    bcfp_pkg::in_item_t  it;
    bcfp_pkg::out_item_t out_reg;
    assign it = in_ch.payload;

    logic [7:0] buf_mem [BUF_BYTES];
    logic [7:0] name_mem [NUM_CMDS * NAME_LEN];
    logic [4:0] len_reg [NUM_CMDS];

    state_t     state_reg;
    logic [FW-1:0] fill_reg;
    logic       in_frame_reg, line_start_reg;
    logic [4:0] count_reg;
    logic [CW-1:0] ci_reg;
    logic [4:0] j_reg;
    logic [FW:0] pos_reg;
    logic [7:0] bdata_reg, ndata_reg;
    logic [3:0] p_reg;
    logic       nonempty_reg, esc_reg, out_valid_reg, after_sum_reg;
    state_t     ret_reg;

    logic [4:0] n_eff, cur_len;
    assign n_eff = (count_reg > 5'(NUM_CMDS)) ? 5'(NUM_CMDS) : count_reg;
    assign cur_len = len_reg[ci_reg];

    assign in_ch.ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg_ready = 1'b1;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.payload = out_reg;

    logic in_acc;
    assign in_acc = in_ch.valid && in_ch.ready;

    // Table and buffer memories: one write port, one registered read port each.
    always_ff @(posedge clk)
    begin
        if (in_acc && it.cmd == bcfp_pkg::CMD_NAME_CHAR && 32'(it.slot) < NUM_CMDS
            && 32'(it.char_pos) < NAME_LEN)
        begin
            name_mem[TW'(32'(it.slot) * NAME_LEN + 32'(it.char_pos))] <= it.data_byte;
        end
        if (in_acc && it.cmd == bcfp_pkg::CMD_BYTE && !line_start_reg && in_frame_reg
            && it.data_byte != bcfp_pkg::CH_CLOSE && 32'(fill_reg) < BUF_BYTES)
        begin
            buf_mem[fill_reg[BW-1:0]] <= it.data_byte;
        end
        if (state_reg == S_MREAD)
        begin
            ndata_reg <= name_mem[TW'(32'(ci_reg) * NAME_LEN + 32'(j_reg))];
        end
        bdata_reg <= buf_mem[pos_reg[BW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg <= '0;
            in_frame_reg <= 1'b0;
            line_start_reg <= 1'b1;
            count_reg <= '0;
            for (int k = 0; k < NUM_CMDS; k++)
            begin
                len_reg[k] <= '0;
            end
            out_valid_reg <= 1'b0;
            ci_reg <= '0;
            j_reg <= '0;
            pos_reg <= '0;
            p_reg <= '0;
            nonempty_reg <= 1'b0;
            esc_reg <= 1'b0;
            after_sum_reg <= 1'b0;
            ret_reg <= S_IDLE;
            out_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                count_reg <= cfg_data;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (out_valid_reg && out_ch.ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                    if (in_acc)
                    begin
                        case (it.cmd)
                            bcfp_pkg::CMD_NAME_LEN:
                            begin
                                if (32'(it.slot) < NUM_CMDS)
                                begin
                                    len_reg[CW'(it.slot)] <= (32'(it.name_length) > NAME_LEN)
                                        ? 5'(NAME_LEN) : it.name_length;
                                end
                            end
                            bcfp_pkg::CMD_BYTE:
                            begin
                                if (line_start_reg)
                                begin
                                    if (it.data_byte == bcfp_pkg::CH_OPEN)
                                    begin
                                        fill_reg <= '0;
                                        in_frame_reg <= 1'b1;
                                        line_start_reg <= 1'b0;
                                    end
                                    else
                                    begin
                                        line_start_reg <= !in_frame_reg
                                            && it.data_byte == bcfp_pkg::CH_NL;
                                    end
                                end
                                else if (!in_frame_reg)
                                begin
                                    if (it.data_byte == bcfp_pkg::CH_NL)
                                    begin
                                        line_start_reg <= 1'b1;
                                    end
                                end
                                else if (it.data_byte == bcfp_pkg::CH_CLOSE)
                                begin
                                    in_frame_reg <= 1'b0;
                                    line_start_reg <= 1'b1;
                                    ci_reg <= '0;
                                    j_reg <= '0;
                                    pos_reg <= '0;
                                    state_reg <= S_MREAD;
                                end
                                else if (32'(fill_reg) >= BUF_BYTES)
                                begin
                                    fill_reg <= '0;
                                    in_frame_reg <= 1'b0;
                                    line_start_reg <= 1'b1;
                                    out_reg <= '{kind: bcfp_pkg::KIND_OVERFLOW,
                                        last: 1'b1, default: '0};
                                    ret_reg <= S_IDLE;
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    fill_reg <= fill_reg + FW'(1);
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_MREAD:
                begin
                    // Entry exhausted or name longer than the buffer: move on.
                    if (5'(ci_reg) >= n_eff)
                    begin
                        fill_reg <= '0;
                        out_reg <= '{kind: bcfp_pkg::KIND_UNKNOWN, last: 1'b1, default: '0};
                        ret_reg <= S_IDLE;
                        state_reg <= S_OUT;
                    end
                    else if (32'(cur_len) > 32'(fill_reg))
                    begin
                        if (5'(ci_reg) + 5'd1 >= n_eff)
                        begin
                            fill_reg <= '0;
                            out_reg <= '{kind: bcfp_pkg::KIND_UNKNOWN, last: 1'b1,
                                default: '0};
                            ret_reg <= S_IDLE;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            ci_reg <= ci_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        state_reg <= S_MCMP;
                    end
                end
                S_MCMP:
                begin
                    if (j_reg == cur_len)
                    begin
                        if (32'(fill_reg) == 32'(cur_len) || bdata_reg == bcfp_pkg::CH_SPACE)
                        begin
                            pos_reg <= (FW + 1)'(cur_len) + (FW + 1)'(1);
                            p_reg <= '0;
                            nonempty_reg <= 1'b0;
                            esc_reg <= 1'b0;
                            state_reg <= S_PREAD;
                        end
                        else
                        begin
                            j_reg <= '0;
                            pos_reg <= '0;
                            if (5'(ci_reg) + 5'd1 >= n_eff)
                            begin
                                fill_reg <= '0;
                                out_reg <= '{kind: bcfp_pkg::KIND_UNKNOWN, last: 1'b1,
                                    default: '0};
                                ret_reg <= S_IDLE;
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                ci_reg <= ci_reg + CW'(1);
                                state_reg <= S_MREAD;
                            end
                        end
                    end
                    else if (ndata_reg != bdata_reg)
                    begin
                        j_reg <= '0;
                        pos_reg <= '0;
                        if (5'(ci_reg) + 5'd1 >= n_eff)
                        begin
                            fill_reg <= '0;
                            out_reg <= '{kind: bcfp_pkg::KIND_UNKNOWN, last: 1'b1,
                                default: '0};
                            ret_reg <= S_IDLE;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            ci_reg <= ci_reg + CW'(1);
                            state_reg <= S_MREAD;
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg + 5'd1;
                        pos_reg <= pos_reg + (FW + 1)'(1);
                        state_reg <= S_MREAD;
                    end
                end
                S_PREAD:
                begin
                    // Buffer byte at pos_reg is registered in this cycle.
                    if (pos_reg >= (FW + 1)'(fill_reg))
                    begin
                        state_reg <= S_SUM;
                    end
                    else
                    begin
                        state_reg <= S_PSTEP;
                    end
                end
                S_PSTEP:
                begin
                    pos_reg <= pos_reg + (FW + 1)'(1);
                    state_reg <= S_PREAD;
                    if (bdata_reg == bcfp_pkg::CH_ESC && !esc_reg)
                    begin
                        esc_reg <= 1'b1;
                    end
                    else if (bdata_reg == bcfp_pkg::CH_SPACE && !esc_reg)
                    begin
                        if (nonempty_reg && 32'(p_reg) < MAX_PARAMS)
                        begin
                            p_reg <= p_reg + 4'd1;
                            nonempty_reg <= 1'b0;
                        end
                    end
                    else
                    begin
                        esc_reg <= 1'b0;
                        if (32'(p_reg) < MAX_PARAMS)
                        begin
                            nonempty_reg <= 1'b1;
                            out_reg <= '{kind: bcfp_pkg::KIND_PARAM,
                                command_index: 4'(ci_reg), param_index: p_reg,
                                param_byte: bdata_reg, param_total: 4'd0, last: 1'b0};
                            ret_reg <= S_PREAD;
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_SUM:
                begin
                    fill_reg <= '0;
                    out_reg <= '{kind: bcfp_pkg::KIND_FOUND, command_index: 4'(ci_reg),
                        param_index: 4'd0, param_byte: 8'd0,
                        param_total: (32'(p_reg) < MAX_PARAMS && nonempty_reg)
                            ? p_reg + 4'd1 : p_reg,
                        last: 1'b1};
                    ret_reg <= S_IDLE;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        if (ret_reg == S_IDLE)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            after_sum_reg <= 1'b1;
                        end
                    end
                    else if (out_ch.ready)
                    begin
                        if (after_sum_reg)
                        begin
                            out_valid_reg <= 1'b0;
                            after_sum_reg <= 1'b0;
                            state_reg <= ret_reg;
                        end
                        else
                        begin
                            out_valid_reg <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
